// ----- rtl/core/n2a_pkg.sv -----
// n2a_pkg: types, constants and character tables shared by the
// number-to-ASCII formatter (converter, sequencer, top level).
// No dependencies.
`default_nettype none

package n2a_pkg;

	localparam int VALUE_WIDTH = 32;
	// magnitude bits of a non-negative value
	localparam int MAG_WIDTH = VALUE_WIDTH - 1;
	// decimal digits needed for 2**MAG_WIDTH - 1 (1233/4096 ~ log10(2))
	localparam int NUM_DIGITS = ((MAG_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_WIDTH = 4 * NUM_DIGITS;
	localparam int BCNT_WIDTH = $clog2(MAG_WIDTH + 1);
	localparam int DCNT_WIDTH = $clog2(NUM_DIGITS + 1);

	localparam int NEG_MSG_LEN = 21;
	localparam int NEG_IDX_WIDTH = $clog2(NEG_MSG_LEN);
	localparam logic [NEG_IDX_WIDTH-1:0] NEG_LAST = NEG_IDX_WIDTH'(NEG_MSG_LEN - 1);

	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_A = 8'd65;
	localparam logic [3:0] HEX_RADIX = 4'd10;

	typedef struct packed {
		logic kind;
		logic signed [VALUE_WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] character;
		logic last;
	} res_t;

	// sequencer -> converter
	typedef struct packed {
		logic load;
		logic shift_digit;
	} dab_ctrl_t;

	// converter -> sequencer
	typedef struct packed {
		logic done;
		logic [3:0] top_digit;
	} dab_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEX,
		ST_NEG,
		ST_CONV,
		ST_DIGITS
	} seq_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] nib8;
		nib8 = {4'b0000, nib};
		if (nib < HEX_RADIX) begin
			return nib8 + CHAR_ZERO;
		end
		return nib8 + (CHAR_A - {4'b0000, HEX_RADIX});
	endfunction

	// CR LF " Negative number " CR LF
	function automatic logic [7:0] neg_char(input logic [NEG_IDX_WIDTH-1:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:    ch = 8'h0D;
			5'd1:    ch = 8'h0A;
			5'd2:    ch = 8'h20;
			5'd3:    ch = 8'h4E;
			5'd4:    ch = 8'h65;
			5'd5:    ch = 8'h67;
			5'd6:    ch = 8'h61;
			5'd7:    ch = 8'h74;
			5'd8:    ch = 8'h69;
			5'd9:    ch = 8'h76;
			5'd10:   ch = 8'h65;
			5'd11:   ch = 8'h20;
			5'd12:   ch = 8'h6E;
			5'd13:   ch = 8'h75;
			5'd14:   ch = 8'h6D;
			5'd15:   ch = 8'h62;
			5'd16:   ch = 8'h65;
			5'd17:   ch = 8'h72;
			5'd18:   ch = 8'h20;
			5'd19:   ch = 8'h0D;
			5'd20:   ch = 8'h0A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/n2a_dabble.sv -----
// n2a_dabble: bit-serial binary to BCD converter (shift and add 3),
// one magnitude bit per cycle; also shifts the digits out MSD first.
// Depends on n2a_pkg.
`default_nettype none

module n2a_dabble (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire n2a_pkg::dab_ctrl_t     ctrl,
	input  wire [n2a_pkg::MAG_WIDTH-1:0] mag,
	output n2a_pkg::dab_stat_t          stat
);
	import n2a_pkg::*;

	logic [MAG_WIDTH-1:0]  bin_q;
	logic [BCD_WIDTH-1:0]  bcd_q;
	logic [BCD_WIDTH-1:0]  adj;
	logic [BCNT_WIDTH-1:0] cnt_q;
	logic                  run_q;
	logic                  done_q;

	// digits at 5 or above get 3 added before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                          : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.load) begin
				run_q <= 1'b1;
				cnt_q <= BCNT_WIDTH'(MAG_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - BCNT_WIDTH'(1);
				if (cnt_q == BCNT_WIDTH'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {adj[BCD_WIDTH-2:0], bin_q[MAG_WIDTH-1]};
			bin_q <= {bin_q[MAG_WIDTH-2:0], 1'b0};
		end else if (ctrl.shift_digit) begin
			bcd_q <= {bcd_q[BCD_WIDTH-5:0], 4'h0};
		end
	end

	assign stat.done      = done_q;
	assign stat.top_digit = bcd_q[BCD_WIDTH-1 -: 4];

endmodule

`default_nettype wire

// ----- rtl/core/n2a_seq.sv -----
// n2a_seq: request sequencer and result register; picks hex, message or
// decimal output, at most one character per cycle. Depends on n2a_pkg.
`default_nettype none

module n2a_seq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire n2a_pkg::req_t           req,
	output logic                         busy,
	output logic                         strobe,
	output n2a_pkg::res_t                result,
	output n2a_pkg::dab_ctrl_t           ctrl,
	output logic [n2a_pkg::MAG_WIDTH-1:0] mag,
	input  wire n2a_pkg::dab_stat_t      stat
);
	import n2a_pkg::*;

	seq_state_t               state_q, state_d;
	logic [NEG_IDX_WIDTH-1:0] idx_q, idx_d;
	logic [DCNT_WIDTH-1:0]    dcnt_q, dcnt_d;
	logic                     seen_q, seen_d;
	logic [7:0]               hex_q, hex_d;
	logic                     strobe_q;
	res_t                     result_q;
	logic                     emit;
	res_t                     res_d;
	logic                     is_last;
	logic                     nz;

	assign mag = req.value[MAG_WIDTH-1:0];

	always_comb begin
		state_d          = state_q;
		idx_d            = idx_q;
		dcnt_d           = dcnt_q;
		seen_d           = seen_q;
		hex_d            = hex_q;
		emit             = 1'b0;
		res_d.character  = 8'h00;
		res_d.last       = 1'b0;
		ctrl.load        = 1'b0;
		ctrl.shift_digit = 1'b0;
		busy             = 1'b1;
		is_last          = (dcnt_q == DCNT_WIDTH'(1));
		nz               = (stat.top_digit != 4'h0);
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					idx_d = '0;
					hex_d = req.value[7:0];
					if (req.kind) begin
						state_d = ST_HEX;
					end else if (req.value[VALUE_WIDTH-1]) begin
						state_d = ST_NEG;
					end else begin
						ctrl.load = 1'b1;
						state_d   = ST_CONV;
					end
				end
			end
			ST_HEX: begin
				emit            = 1'b1;
				res_d.character = hex_char(idx_q[0] ? hex_q[3:0] : hex_q[7:4]);
				res_d.last      = idx_q[0];
				idx_d           = idx_q + NEG_IDX_WIDTH'(1);
				if (idx_q[0]) begin
					state_d = ST_IDLE;
				end
			end
			ST_NEG: begin
				emit            = 1'b1;
				res_d.character = neg_char(idx_q);
				res_d.last      = (idx_q == NEG_LAST);
				idx_d           = idx_q + NEG_IDX_WIDTH'(1);
				if (idx_q == NEG_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_CONV: begin
				if (stat.done) begin
					dcnt_d  = DCNT_WIDTH'(NUM_DIGITS);
					seen_d  = 1'b0;
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				// leading zeros are dropped, but the units digit always goes out
				ctrl.shift_digit = 1'b1;
				emit             = nz | seen_q | is_last;
				res_d.character  = CHAR_ZERO + {4'h0, stat.top_digit};
				res_d.last       = is_last;
				seen_d           = seen_q | nz;
				dcnt_d           = dcnt_q - DCNT_WIDTH'(1);
				if (is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			dcnt_q   <= '0;
			seen_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			dcnt_q   <= dcnt_d;
			seen_q   <= seen_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		hex_q <= hex_d;
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/number_to_ascii_formatter_top.sv -----
// number_to_ascii_formatter_top: top level of the number-to-ASCII formatter.
// Depends on n2a_pkg, n2a_dabble, n2a_seq.
//
// Usage:
//   Request channel: drive req (kind, value) and raise start. The request
//   transfer happens on a rising edge with start high and busy low; busy
//   then stays high until the last character has been registered.
//   Result channel: each character appears on result for one cycle with
//   strobe high; result.last marks the final character of the request.
//   The receiver cannot stall: every strobe cycle is a completed transfer.
//   Per request kind:
//     hex (kind = 1): 2 characters.
//     negative decimal: 21 message characters back to back.
//     non-negative decimal: bit-serial binary to BCD conversion of the
//       MAG_WIDTH (31) magnitude bits, a hand-off step, then NUM_DIGITS
//       (10) digits in which leading zeros are dropped.
//   A new request may transfer the cycle after busy falls.
//   Reset (arst_n low) returns to idle and drops any request in flight.
`default_nettype none

module number_to_ascii_formatter_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire n2a_pkg::req_t  req,
	output logic                busy,
	output logic                strobe,
	output n2a_pkg::res_t       result
);
	import n2a_pkg::*;

	dab_ctrl_t            ctrl;
	dab_stat_t            stat;
	logic [MAG_WIDTH-1:0] mag;

	// sequencer: request decode, message/hex tables, digit emission
	n2a_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.result (result),
		.ctrl   (ctrl),
		.mag    (mag),
		.stat   (stat)
	);

	// converter: one bit per cycle into BCD, then digits out MSD first
	n2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag    (mag),
		.stat   (stat)
	);

`ifndef SYNTHESIS
	// an accepted request always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer did not raise busy");

	// the final character ends the request: block is idle when it shows
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy still high on final character");

	// any other character belongs to a request still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final character while idle");
`endif

endmodule

`default_nettype wire
